[sv/ssb_pkg.sv]
package ssb_pkg;

    // Frame capacity and the widths that follow from it.
    localparam int MAX_SPRITES      = 32;
    localparam int VERTS_PER_SPRITE = 6;
    localparam int IDX_W            = $clog2(MAX_SPRITES);
    localparam int CNT_W            = $clog2(MAX_SPRITES + 1);

    // Fixed field widths of the stream payloads.
    localparam int DEPTH_W = 16;
    localparam int TEX_W   = 16;
    localparam int SIDX_W  = 5;
    localparam int OFF_W   = 8;
    localparam int IN_W    = DEPTH_W + TEX_W;
    localparam int OUT_W   = SIDX_W + TEX_W + 1 + OFF_W + 1 + OFF_W + 1;

    // Sort orders selected by the mode register.
    typedef enum logic [1:0] {
        MODE_DEPTH_DESC = 2'd0,
        MODE_DEPTH_ASC  = 2'd1,
        MODE_TEX_ASC    = 2'd2,
        MODE_ARRIVAL    = 2'd3
    } t_mode;

    // One stored sprite.
    typedef struct packed {
        logic        [SIDX_W-1:0]  idx;
        logic        [TEX_W-1:0]   tex;
        logic signed [DEPTH_W-1:0] depth;
    } t_entry;

    // Compare request for the shared ordering unit.
    typedef struct packed {
        t_mode  mode;
        t_entry cand;
        t_entry held;
    } t_cmp_req;

endpackage

[sv/ssb_order.sv]
module ssb_order
    import ssb_pkg::*;
(
    input  t_cmp_req i_req,
    output logic     o_cand_first
);

    // Strict ordering test: equal keys never move, which keeps the sort stable.
    always_comb begin
        case (i_req.mode)
            MODE_DEPTH_DESC: o_cand_first = i_req.cand.depth > i_req.held.depth;
            MODE_DEPTH_ASC:  o_cand_first = i_req.cand.depth < i_req.held.depth;
            MODE_TEX_ASC:    o_cand_first = i_req.cand.tex < i_req.held.tex;
            default:         o_cand_first = 1'b0;
        endcase
    end

endmodule

[sv/sprite_sort_and_batch_top.sv]
// Load: one sprite beat per cycle while collecting a frame, ready stays high until the last beat.
// Sort: insertion sort on one compare unit and one write and one read store port; each sprite
// after the first is read as the key and shifts up every entry ahead of it that it passes.
// Emit: each sorted entry is read, the next one is read to decide the batch close, and the result
// is registered in S_EMIT_OUT, which holds under output stalls; the next frame follows at once.
// Reset (i_rst_n low, synchronous) clears the count, overflow flag, mode and handshakes.
module sprite_sort_and_batch_top
    import ssb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    // Configuration write: sort_mode.
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [1:0]       i_cfg_data,
    // Sprite input. tdata from bit 0: depth_key[15:0], texture_id[15:0].
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  logic [IN_W-1:0]  i_s_axis_tdata,
    input  logic             i_s_axis_tlast,
    // Result output. tdata from bit 0: sprite_index[4:0], sprite_texture[15:0],
    // batch_first, batch_offset[7:0], batch_close, batch_vertex_count[7:0], dropped_any.
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    output logic [OUT_W-1:0] o_m_axis_tdata,
    output logic             o_m_axis_tlast
);

    typedef enum logic [2:0] {
        S_LOAD,
        S_SORT_NEXT,
        S_SORT_KEY,
        S_SORT_CMP,
        S_SORT_PUT,
        S_EMIT_CUR,
        S_EMIT_NXT,
        S_EMIT_OUT
    } t_state;

    localparam logic [OFF_W-1:0] VERT_STEP = OFF_W'(VERTS_PER_SPRITE);

    t_state             r_state, n_state;
    t_mode              r_mode, n_mode;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_ovf, n_ovf;
    logic [CNT_W-1:0]   r_n, n_n;
    logic [CNT_W-1:0]   r_i, n_i;
    logic [CNT_W-1:0]   r_j, n_j;
    logic [CNT_W-1:0]   r_k, n_k;
    t_entry             r_key, n_key;
    t_entry             r_cur, n_cur;
    logic               r_close, n_close;
    logic [TEX_W-1:0]   r_prev_tex, n_prev_tex;
    logic [OFF_W-1:0]   r_boff, n_boff;
    logic [OFF_W-1:0]   r_koff, n_koff;
    logic               r_m_valid, n_m_valid;
    logic [OUT_W-1:0]   r_m_data, n_m_data;
    logic               r_m_last, n_m_last;

    // Sprite store, one write and one registered read port.
    t_entry             r_mem [MAX_SPRITES];
    t_entry             r_rd_data;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    t_entry             wr_data;

    t_cmp_req           cmp_req;
    logic               cand_first;

    logic               in_beat;
    logic               out_free;
    logic               e_first;
    logic               e_last;
    logic [OFF_W-1:0]   e_off;
    logic [OFF_W-1:0]   e_cnt;
    logic [CNT_W-1:0]   k_inc;
    logic [CNT_W-1:0]   k_inc2;
    t_entry             in_entry;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == S_LOAD);
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;
    assign o_m_axis_tlast  = r_m_last;

    assign in_beat  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_m_valid || i_m_axis_tready;
    assign k_inc    = r_k + CNT_W'(1);
    assign k_inc2   = r_k + CNT_W'(2);

    assign in_entry.idx   = r_count[SIDX_W-1:0];
    assign in_entry.tex   = i_s_axis_tdata[DEPTH_W +: TEX_W];
    assign in_entry.depth = i_s_axis_tdata[DEPTH_W-1:0];

    // Shared compare unit: held key against the entry just read.
    assign cmp_req.mode = r_mode;
    assign cmp_req.cand = r_key;
    assign cmp_req.held = r_rd_data;

    ssb_order u_order (
        .i_req        (cmp_req),
        .o_cand_first (cand_first)
    );

    // Batch fields of the sprite held in r_cur.
    assign e_first = (r_k == '0) || (r_cur.tex != r_prev_tex);
    assign e_last  = (k_inc == r_n);
    assign e_off   = e_first ? r_koff : r_boff;
    assign e_cnt   = r_close ? (r_koff + VERT_STEP - e_off) : '0;

    // Store access.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Sequencer next state.
    always_comb begin
        n_state    = r_state;
        n_mode     = r_mode;
        n_count    = r_count;
        n_ovf      = r_ovf;
        n_n        = r_n;
        n_i        = r_i;
        n_j        = r_j;
        n_k        = r_k;
        n_key      = r_key;
        n_cur      = r_cur;
        n_close    = r_close;
        n_prev_tex = r_prev_tex;
        n_boff     = r_boff;
        n_koff     = r_koff;
        n_m_valid  = r_m_valid && !i_m_axis_tready;
        n_m_data   = r_m_data;
        n_m_last   = r_m_last;
        rd_en      = 1'b0;
        rd_addr    = '0;
        wr_en      = 1'b0;
        wr_addr    = r_count[IDX_W-1:0];
        wr_data    = in_entry;

        if (i_cfg_valid) begin
            n_mode = t_mode'(i_cfg_data);
        end

        case (r_state)
            S_LOAD: begin
                if (in_beat) begin
                    if (r_count < CNT_W'(MAX_SPRITES)) begin
                        wr_en   = 1'b1;
                        n_count = r_count + CNT_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_s_axis_tlast) begin
                        n_n     = n_count;
                        n_i     = CNT_W'(1);
                        n_state = S_SORT_NEXT;
                    end
                end
            end
            S_SORT_NEXT: begin
                rd_en = 1'b1;
                if (r_i >= r_n) begin
                    // Sort done: fetch the first sorted entry.
                    rd_addr = '0;
                    n_k     = '0;
                    n_koff  = '0;
                    n_boff  = '0;
                    n_state = S_EMIT_CUR;
                end else begin
                    rd_addr = r_i[IDX_W-1:0];
                    n_j     = r_i;
                    n_state = S_SORT_KEY;
                end
            end
            S_SORT_KEY: begin
                n_key   = r_rd_data;
                rd_en   = 1'b1;
                rd_addr = IDX_W'(r_j - CNT_W'(1));
                n_state = S_SORT_CMP;
            end
            S_SORT_CMP: begin
                wr_en   = 1'b1;
                wr_addr = r_j[IDX_W-1:0];
                if (cand_first) begin
                    // Shift the later entry up one place and keep scanning down.
                    wr_data = r_rd_data;
                    n_j     = r_j - CNT_W'(1);
                    if (r_j == CNT_W'(1)) begin
                        n_state = S_SORT_PUT;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = IDX_W'(r_j - CNT_W'(2));
                    end
                end else begin
                    wr_data = r_key;
                    n_i     = r_i + CNT_W'(1);
                    n_state = S_SORT_NEXT;
                end
            end
            S_SORT_PUT: begin
                wr_en   = 1'b1;
                wr_addr = r_j[IDX_W-1:0];
                wr_data = r_key;
                n_i     = r_i + CNT_W'(1);
                n_state = S_SORT_NEXT;
            end
            S_EMIT_CUR: begin
                n_cur = r_rd_data;
                if (k_inc == r_n) begin
                    n_close = 1'b1;
                    n_state = S_EMIT_OUT;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = k_inc[IDX_W-1:0];
                    n_state = S_EMIT_NXT;
                end
            end
            S_EMIT_NXT: begin
                n_close = (r_rd_data.tex != r_cur.tex);
                n_state = S_EMIT_OUT;
            end
            S_EMIT_OUT: begin
                if (out_free) begin
                    n_m_valid  = 1'b1;
                    n_m_last   = e_last;
                    n_m_data   = {r_ovf, e_cnt, r_close, e_off, e_first,
                                  r_cur.tex, r_cur.idx};
                    n_prev_tex = r_cur.tex;
                    n_boff     = e_off;
                    n_koff     = r_koff + VERT_STEP;
                    n_k        = k_inc;
                    if (e_last) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_state = S_LOAD;
                    end else begin
                        // The next entry already sits in the read register.
                        n_cur = r_rd_data;
                        if (k_inc2 == r_n) begin
                            n_close = 1'b1;
                        end else begin
                            rd_en   = 1'b1;
                            rd_addr = k_inc2[IDX_W-1:0];
                            n_state = S_EMIT_NXT;
                        end
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_mode    <= MODE_DEPTH_DESC;
            r_count   <= '0;
            r_ovf     <= 1'b0;
            r_m_valid <= 1'b0;
            r_m_last  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_mode    <= n_mode;
            r_count   <= n_count;
            r_ovf     <= n_ovf;
            r_m_valid <= n_m_valid;
            r_m_last  <= n_m_last;
        end
        r_n        <= n_n;
        r_i        <= n_i;
        r_j        <= n_j;
        r_k        <= n_k;
        r_key      <= n_key;
        r_cur      <= n_cur;
        r_close    <= n_close;
        r_prev_tex <= n_prev_tex;
        r_boff     <= n_boff;
        r_koff     <= n_koff;
        r_m_data   <= n_m_data;
    end

    // The fill count never passes the store depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_SPRITES))
        else $error("sprite count beyond capacity");

    // The scan position stays inside the part already sorted.
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SORT_CMP) |-> (r_j != '0 && r_j <= r_i && r_i < r_n))
        else $error("insertion scan out of range");

    // The final beat of a frame always closes its batch.
    a_final_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && r_m_last) |-> r_m_data[SIDX_W + TEX_W + 1 + OFF_W])
        else $error("final beat does not close a batch");

    // A closing beat carries a nonzero vertex count.
    a_close_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && r_m_data[SIDX_W + TEX_W + 1 + OFF_W])
            |-> (r_m_data[SIDX_W + TEX_W + 2 + OFF_W +: OFF_W] != '0))
        else $error("closing beat with zero vertex count");

    // Loading resumes only after the final emit, so input is never taken while emitting or sorting.
    a_no_load_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == S_LOAD) |-> $past(r_state == S_EMIT_OUT && out_free))
        else $error("returned to load outside a final emit");

endmodule

[tb/sv/ssb_result_checker.sv]
// Watches the configuration, sprite and result channels of the sprite sort and batch
// block. A local copy of the frame store is loaded from accepted sprite beats, sorted
// by the current mode when a frame closes, and turned into the expected result beats.
// Each accepted result beat is compared field by field with the oldest expectation.
module ssb_result_checker
    import ssb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    input  logic             i_cfg_ready,
    input  logic [1:0]       i_cfg_data,
    input  logic             i_in_valid,
    input  logic             i_in_ready,
    input  logic [IN_W-1:0]  i_in_data,
    input  logic             i_in_last,
    input  logic             i_out_valid,
    input  logic             i_out_ready,
    input  logic [OUT_W-1:0] i_out_data,
    input  logic             i_out_last,
    output int               o_fail_count,
    output int               o_pending
);

    // Result tdata layout, last member in the lowest bits.
    typedef struct packed {
        logic              dropped;
        logic [OFF_W-1:0]  vcount;
        logic              close;
        logic [OFF_W-1:0]  offset;
        logic              first;
        logic [TEX_W-1:0]  tex;
        logic [SIDX_W-1:0] sidx;
    } t_sprite_beat;

    t_entry       frame_sprites[MAX_SPRITES];
    int           sprites_held;
    logic         frame_overflow;
    t_mode        sort_mode;
    t_sprite_beat batch_beats_due[$];
    logic         final_flags_due[$];
    int           mismatches;

    initial begin
        mismatches   = 0;
        sprites_held = 0;
        o_fail_count = 0;
        o_pending    = 0;
    end

    // One line per mismatch, and the count goes up.
    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got != want) begin
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
        end
    endtask

    // True when sprite a must come out ahead of sprite b; ties keep arrival order.
    function automatic logic sorts_ahead(input t_entry a, input t_entry b);
        case (sort_mode)
            MODE_DEPTH_DESC: return a.depth > b.depth;
            MODE_DEPTH_ASC:  return a.depth < b.depth;
            MODE_TEX_ASC:    return a.tex < b.tex;
            default:         return 1'b0;
        endcase
    endfunction

    // Stable sort of the held frame, then one beat per sprite with its batch fields.
    task automatic sort_and_batch_frame();
        t_entry       order[MAX_SPRITES];
        t_entry       tmp;
        t_sprite_beat beat;
        int           j;
        int           start;
        logic         opens;
        logic         closes;
        logic         is_final;
        order = frame_sprites;
        start = 0;
        for (int i = 1; i < sprites_held; i++) begin
            j = i;
            while (j > 0 && sorts_ahead(order[j], order[j-1])) begin
                tmp        = order[j];
                order[j]   = order[j-1];
                order[j-1] = tmp;
                j--;
            end
        end
        for (int k = 0; k < sprites_held; k++) begin
            opens  = (k == 0) || (order[k].tex != order[k-1].tex);
            closes = (k + 1 == sprites_held) || (order[k+1].tex != order[k].tex);
            if (opens) begin
                start = k;
            end
            beat.sidx    = order[k].idx;
            beat.tex     = order[k].tex;
            beat.first   = opens;
            beat.offset  = OFF_W'(start * VERTS_PER_SPRITE);
            beat.close   = closes;
            beat.vcount  = closes ? OFF_W'((k - start + 1) * VERTS_PER_SPRITE) : '0;
            beat.dropped = frame_overflow;
            is_final     = (k + 1 == sprites_held);
            batch_beats_due = {batch_beats_due, beat};
            final_flags_due = {final_flags_due, is_final};
        end
    endtask

    // Channel monitor: compare results, track the mode, load sprites.
    always @(posedge i_clk) begin : monitor
        t_sprite_beat got;
        t_sprite_beat want;
        logic         want_last;
        if (!i_rst_n) begin
            sprites_held   = 0;
            frame_overflow = 1'b0;
            sort_mode      = MODE_DEPTH_DESC;
            batch_beats_due.delete();
            final_flags_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got = t_sprite_beat'(i_out_data);
                if (batch_beats_due.size() == 0) begin
                    report_mismatch($sformatf("result beat with nothing expected, tdata %h",
                                              i_out_data));
                end else begin
                    want      = batch_beats_due.pop_front();
                    want_last = final_flags_due.pop_front();
                    check_field("sprite_index", got.sidx, want.sidx);
                    check_field("sprite_texture", got.tex, want.tex);
                    check_field("batch_first", got.first, want.first);
                    check_field("batch_offset", got.offset, want.offset);
                    check_field("batch_close", got.close, want.close);
                    check_field("batch_vertex_count", got.vcount, want.vcount);
                    check_field("dropped_any", got.dropped, want.dropped);
                    check_field("final_result", i_out_last, want_last);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                sort_mode = t_mode'(i_cfg_data);
            end
            if (i_in_valid && i_in_ready) begin
                if (sprites_held < MAX_SPRITES) begin
                    frame_sprites[sprites_held].idx   = SIDX_W'(sprites_held);
                    frame_sprites[sprites_held].tex   = i_in_data[DEPTH_W +: TEX_W];
                    frame_sprites[sprites_held].depth = i_in_data[DEPTH_W-1:0];
                    sprites_held++;
                end else begin
                    frame_overflow = 1'b1;
                end
                if (i_in_last) begin
                    sort_and_batch_frame();
                    sprites_held   = 0;
                    frame_overflow = 1'b0;
                end
            end
        end
        o_fail_count = mismatches;
        o_pending    = batch_beats_due.size();
    end

endmodule

[tb/sv/sprite_sort_and_batch_top_tb.sv]
// Drives frames of sprites into the sort and batch block under all four sort modes
// and several idle profiles, while the checker predicts and compares every result.
module sprite_sort_and_batch_top_tb;
    import ssb_pkg::*;

    localparam int CYCLE_LIMIT  = 800000;
    localparam int SETTLE       = 24;
    localparam int HOLD_CYCLES  = 3000;
    localparam int PHASE_ITEMS  = 48;

    logic             i_clk;
    logic             i_rst_n         = 1'b0;
    logic             i_cfg_valid     = 1'b0;
    logic [1:0]       i_cfg_data      = '0;
    logic             i_s_axis_tvalid = 1'b0;
    logic [IN_W-1:0]  i_s_axis_tdata  = '0;
    logic             i_s_axis_tlast  = 1'b0;
    logic             i_m_axis_tready = 1'b0;
    logic             o_cfg_ready;
    logic             o_s_axis_tready;
    logic             o_m_axis_tvalid;
    logic [OUT_W-1:0] o_m_axis_tdata;
    logic             o_m_axis_tlast;

    int   fail_count;
    int   beats_pending;
    int   cycles        = 0;
    int   tx_idle_pct   = 0;
    int   rx_stall_pct  = 0;
    logic hold_req      = 1'b0;
    int   hold_left     = 0;

    sprite_sort_and_batch_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    ssb_result_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_s_axis_tvalid),
        .i_in_ready   (o_s_axis_tready),
        .i_in_data    (i_s_axis_tdata),
        .i_in_last    (i_s_axis_tlast),
        .i_out_valid  (o_m_axis_tvalid),
        .i_out_ready  (i_m_axis_tready),
        .i_out_data   (o_m_axis_tdata),
        .i_out_last   (o_m_axis_tlast),
        .o_fail_count (fail_count),
        .o_pending    (beats_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Result side: random stalls, plus a long hold-off when requested.
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
        if (hold_req || hold_left > 1) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Offer one sprite beat, with random gaps ahead of it, and wait until it is taken.
    task automatic send_sprite(input logic [DEPTH_W-1:0] depth,
                               input logic [TEX_W-1:0] tex, input logic last);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {tex, depth};
        i_s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_axis_tready) begin
            @(posedge i_clk);
        end
    endtask

    // Random frame: depths and textures often collide so ties and batches show up.
    task automatic send_random_frame(input int len);
        logic [DEPTH_W-1:0] depth;
        logic [TEX_W-1:0]   tex;
        int                 r;
        for (int i = 0; i < len; i++) begin
            r = $urandom_range(99);
            if (r < 35) begin
                depth = DEPTH_W'($urandom_range(2)) - 16'd1;
            end else if (r < 45) begin
                depth = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
            end else begin
                depth = DEPTH_W'($urandom);
            end
            r = $urandom_range(99);
            if (r < 50) begin
                tex = TEX_W'($urandom_range(3));
            end else if (r < 55) begin
                tex = 16'hFFFF;
            end else begin
                tex = TEX_W'($urandom);
            end
            send_sprite(depth, tex, i == len - 1);
        end
    endtask

    // Let every expected result come out, then give the block time to settle.
    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (beats_pending != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_sort_mode(input t_mode mode);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= mode;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Stimulus and verdict.
    initial begin : stimulus
        int phase_items;
        int len;
        int r;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Depth extremes, equal depths kept in arrival order, textures 0 and all ones.
        write_sort_mode(MODE_DEPTH_DESC);
        send_sprite(16'h7FFF, 16'h0000, 1'b0);
        send_sprite(16'h8000, 16'hFFFF, 1'b0);
        send_sprite(16'h0000, 16'h0007, 1'b0);
        send_sprite(16'h7FFF, 16'h0007, 1'b0);
        send_sprite(16'hFFFF, 16'hFFFF, 1'b1);
        drain_results();

        // A frame of one sprite, then ties under ascending depth.
        write_sort_mode(MODE_DEPTH_ASC);
        send_sprite(16'h8000, 16'h5555, 1'b1);
        send_sprite(16'h0100, 16'h0001, 1'b0);
        send_sprite(16'h0100, 16'h0002, 1'b0);
        send_sprite(16'hFF00, 16'h0001, 1'b0);
        send_sprite(16'h0100, 16'h0001, 1'b1);
        drain_results();

        // Texture order gathers equal textures into batches.
        write_sort_mode(MODE_TEX_ASC);
        send_sprite(16'h0010, 16'h0003, 1'b0);
        send_sprite(16'h0020, 16'h0001, 1'b0);
        send_sprite(16'h0030, 16'h0003, 1'b0);
        send_sprite(16'h0040, 16'h0001, 1'b0);
        send_sprite(16'h0050, 16'h0002, 1'b0);
        send_sprite(16'h0060, 16'h0003, 1'b1);
        drain_results();

        // The unused mode keeps arrival order.
        write_sort_mode(MODE_ARRIVAL);
        send_sprite(16'h0001, 16'h0005, 1'b0);
        send_sprite(16'h0002, 16'h0005, 1'b0);
        send_sprite(16'h0003, 16'h0009, 1'b0);
        send_sprite(16'h0004, 16'h0005, 1'b1);

        // Random phases, each with its own mode and idle profile.
        for (int p = 0; p < 8; p++) begin
            drain_results();
            write_sort_mode(t_mode'((p * 3 + 1) % 4));
            case (p % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 45; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 45; end
                default: begin tx_idle_pct = 18; rx_stall_pct = 18; end
            endcase
            phase_items = 0;
            // Results held back for a long time while more frames are offered.
            if (p == 2) begin
                hold_req <= 1'b1;
                @(posedge i_clk);
                hold_req <= 1'b0;
                send_random_frame(24);
                send_random_frame(20);
                phase_items = 44;
            end
            while (phase_items < PHASE_ITEMS) begin
                r = $urandom_range(99);
                if (p == 5 && phase_items == 0) begin
                    len = 34;
                end else if (r < 60) begin
                    len = $urandom_range(8, 1);
                end else if (r < 85) begin
                    len = $urandom_range(20, 9);
                end else if (r < 93) begin
                    len = $urandom_range(MAX_SPRITES, 21);
                end else begin
                    len = $urandom_range(MAX_SPRITES + 4, MAX_SPRITES + 1);
                end
                send_random_frame(len);
                phase_items += len;
            end
        end
        drain_results();

        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
